FILE: sv/dtfp_pkg.sv
// package: payload and job types, character codes, multiply-by-ten helper
package dtfp_pkg;

    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [4:0] FRAC_COUNT_MAX = 5'd31;

    // register indexes
    localparam logic REG_FRACTION_DIGITS = 1'b0;
    localparam logic REG_UNIT_SCALE      = 1'b1;

    typedef struct packed {
        logic [7:0] ch;
        logic       char_present;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [63:0] amount;
        logic        amount_valid;
    } out_item_t;

    typedef struct packed {
        logic [4:0]  fraction_digits;
        logic [63:0] unit_scale;
    } cfg_t;

    // one finished string handed from front to back
    typedef struct packed {
        logic        ok;
        logic [63:0] whole;
        logic [63:0] frac;
        logic [4:0]  frac_count;
    } job_t;

    // acc * 10 + d, msb flags overflow past 64 bits
    function automatic logic [64:0] mac10(input logic [63:0] acc, input logic [3:0] d);
        logic [67:0] wide;
        wide = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {64'b0, d};
        return {|wide[67:64], wide[63:0]};
    endfunction

endpackage

FILE: sv/decimal_text_to_fixed_point_top.sv
// top level: decimal amount text to fixed-point amount, with register port
//
// channel  dir  payload                         handshake
// s_       in   ch, char_present, is_last       s_valid / s_ready
// m_       out  amount, amount_valid            m_valid / m_ready
// apb      in   fraction_digits @0, unit_scale @8  psel/penable/pwrite, pready high
//
// the front end takes one character beat per cycle while the job queue has room
// each string (on its last beat) becomes a job; the back end pads its fraction
// (padding = fraction_digits - fraction digits seen, 0 to 31, none for a
// rejected string) with one multiply-by-ten step a cycle, then forms four
// 32x32 partial products
// reset is synchronous and active low; no clearing pass is needed
// a stalled m_ready holds the output register, then the back end, then the queue,
// and only then s_ready drops
module decimal_text_to_fixed_point_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    // input character beats
    input  logic                s_valid,
    output logic                s_ready,
    input  dtfp_pkg::in_item_t  s_data,
    // result beats
    output logic                m_valid,
    input  logic                m_ready,
    output dtfp_pkg::out_item_t m_data,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    output logic [63:0]         prdata,
    output logic                pready
);
    import dtfp_pkg::*;

    logic [4:0]  fraction_digits_reg;
    logic [63:0] unit_scale_reg;
    cfg_t        cfg;
    logic        reg_write;
    logic        reg_sel;

    logic        push_valid;
    job_t        push_data;
    logic        q_full;
    logic        q_empty;
    logic        pop;
    job_t        q_data;

    // registers are decoded on the 8-byte slot bit only
    assign pready    = 1'b1;
    assign reg_sel   = paddr[3];
    assign reg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fraction_digits_reg <= 5'd0;
            unit_scale_reg      <= 64'd1;
        end else if (reg_write) begin
            if (reg_sel == REG_FRACTION_DIGITS) begin
                fraction_digits_reg <= pwdata[4:0];
            end else begin
                unit_scale_reg <= pwdata;
            end
        end
    end

    // read mux
    always_comb begin
        case (reg_sel)
            REG_FRACTION_DIGITS: prdata = {59'b0, fraction_digits_reg};
            default:             prdata = unit_scale_reg;
        endcase
    end

    assign cfg.fraction_digits = fraction_digits_reg;
    assign cfg.unit_scale      = unit_scale_reg;

    // character parsing, one beat a cycle while the queue has room
    dtfp_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .push_valid (push_valid),
        .push_data  (push_data),
        .q_full     (q_full)
    );

    // finished strings waiting for the back end
    dtfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    // padding, scaling, sum and result register
    dtfp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_data  (q_data),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

FILE: sv/dtfp_front.sv
// front end: takes one character per beat, accumulates whole and fraction parts
module dtfp_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  dtfp_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  dtfp_pkg::in_item_t s_data,
    output logic              push_valid,
    output dtfp_pkg::job_t    push_data,
    input  logic              q_full
);
    import dtfp_pkg::*;

    logic        in_fraction_reg, in_fraction_next;
    logic [63:0] whole_acc_reg, whole_acc_next;
    logic        whole_seen_reg, whole_seen_next;
    logic [63:0] frac_acc_reg, frac_acc_next;
    logic [4:0]  frac_count_reg, frac_count_next;
    logic        error_flag_reg, error_flag_next;

    logic        accept;
    logic        is_digit;
    logic [3:0]  digit;
    logic [64:0] whole_mac;
    logic [64:0] frac_mac;
    logic [4:0]  count_inc;

    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign is_digit = (s_data.ch >= CH_ZERO) && (s_data.ch <= CH_NINE);
    assign digit    = s_data.ch[3:0];

    assign whole_mac = mac10(whole_acc_reg, digit);
    assign frac_mac  = mac10(frac_acc_reg, digit);
    assign count_inc = (frac_count_reg < FRAC_COUNT_MAX) ? frac_count_reg + 5'd1
                                                         : frac_count_reg;

    always_comb begin
        in_fraction_next = in_fraction_reg;
        whole_acc_next   = whole_acc_reg;
        whole_seen_next  = whole_seen_reg;
        frac_acc_next    = frac_acc_reg;
        frac_count_next  = frac_count_reg;
        error_flag_next  = error_flag_reg;
        if (s_data.char_present) begin
            if (!in_fraction_reg) begin
                if (s_data.ch == CH_DOT) begin
                    in_fraction_next = 1'b1;
                end else if (is_digit) begin
                    whole_seen_next = 1'b1;
                    if (whole_mac[64]) begin
                        error_flag_next = 1'b1;
                    end else begin
                        whole_acc_next = whole_mac[63:0];
                    end
                end else begin
                    // minus sign and any other character
                    error_flag_next = 1'b1;
                end
            end else begin
                if (!is_digit) begin
                    error_flag_next = 1'b1;
                end else begin
                    frac_count_next = count_inc;
                    if (count_inc > cfg.fraction_digits) begin
                        error_flag_next = 1'b1;
                    end else if (frac_mac[64]) begin
                        error_flag_next = 1'b1;
                    end else begin
                        frac_acc_next = frac_mac[63:0];
                    end
                end
            end
        end
    end

    // a seen digit implies a non-empty string
    assign push_valid            = accept && s_data.is_last;
    assign push_data.ok          = whole_seen_next && !error_flag_next;
    assign push_data.whole       = whole_acc_next;
    assign push_data.frac        = frac_acc_next;
    assign push_data.frac_count  = frac_count_next;

    always_ff @(posedge aclk) begin
        if (!aresetn || (accept && s_data.is_last)) begin
            in_fraction_reg <= 1'b0;
            whole_acc_reg   <= '0;
            whole_seen_reg  <= 1'b0;
            frac_acc_reg    <= '0;
            frac_count_reg  <= '0;
            error_flag_reg  <= 1'b0;
        end else if (accept) begin
            in_fraction_reg <= in_fraction_next;
            whole_acc_reg   <= whole_acc_next;
            whole_seen_reg  <= whole_seen_next;
            frac_acc_reg    <= frac_acc_next;
            frac_count_reg  <= frac_count_next;
            error_flag_reg  <= error_flag_next;
        end
    end

endmodule

FILE: sv/dtfp_queue.sv
// short job queue between front and back
module dtfp_queue #(
    parameter int DEPTH = 4
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dtfp_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output dtfp_pkg::job_t pop_data,
    output logic           empty
);
    import dtfp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop && !empty) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if ((push && !full) && !(pop && !empty)) begin
            count_next = count_reg + CNT_W'(1);
        end else if (!(push && !full) && (pop && !empty)) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/dtfp_back.sv
// back end: fraction padding, whole times base unit, final sum and output register
module dtfp_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  dtfp_pkg::cfg_t     cfg,
    input  logic               q_empty,
    input  dtfp_pkg::job_t     q_data,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output dtfp_pkg::out_item_t m_data
);
    import dtfp_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PAD  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_SUM  = 2'd3;

    localparam logic [2:0] MUL_STEPS = 3'd4;

    logic [1:0]   state_reg, state_next;
    logic         ok_reg, ok_next;
    logic [63:0]  whole_reg, whole_next;
    logic [63:0]  frac_reg, frac_next;
    logic [4:0]   pad_reg, pad_next;
    logic [2:0]   step_reg, step_next;
    logic [63:0]  pp_reg, pp_next;
    logic [127:0] prod_reg, prod_next;
    logic         out_valid_reg, out_valid_next;
    out_item_t    out_reg, out_next;

    logic [64:0]  pad_mac;
    logic [31:0]  op_a, op_b;
    logic [1:0]   prev_step;
    logic [127:0] pp_shifted;
    logic [64:0]  final_sum;
    logic         out_free;

    assign pad_mac   = mac10(frac_reg, 4'd0);
    assign prev_step = step_reg[1:0] - 2'd1;
    assign final_sum = {1'b0, prod_reg[63:0]} + {1'b0, frac_reg};
    assign out_free  = !out_valid_reg || m_ready;

    // partial product operands: lo*lo, lo*hi, hi*lo, hi*hi
    always_comb begin
        case (step_reg[1:0])
            2'd0: begin
                op_a = whole_reg[31:0];
                op_b = cfg.unit_scale[31:0];
            end
            2'd1: begin
                op_a = whole_reg[31:0];
                op_b = cfg.unit_scale[63:32];
            end
            2'd2: begin
                op_a = whole_reg[63:32];
                op_b = cfg.unit_scale[31:0];
            end
            default: begin
                op_a = whole_reg[63:32];
                op_b = cfg.unit_scale[63:32];
            end
        endcase
    end

    always_comb begin
        case (prev_step)
            2'd0:    pp_shifted = {64'b0, pp_reg};
            2'd1:    pp_shifted = {32'b0, pp_reg, 32'b0};
            2'd2:    pp_shifted = {32'b0, pp_reg, 32'b0};
            default: pp_shifted = {pp_reg, 64'b0};
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        ok_next        = ok_reg;
        whole_next     = whole_reg;
        frac_next      = frac_reg;
        pad_next       = pad_reg;
        step_next      = step_reg;
        pp_next        = pp_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    pop        = 1'b1;
                    ok_next    = q_data.ok;
                    whole_next = q_data.whole;
                    frac_next  = q_data.frac;
                    pad_next   = q_data.ok ? cfg.fraction_digits - q_data.frac_count : 5'd0;
                    state_next = ST_PAD;
                end
            end
            ST_PAD: begin
                if (pad_reg == 5'd0 || !ok_reg) begin
                    step_next  = '0;
                    prod_next  = '0;
                    state_next = ST_MUL;
                end else begin
                    if (pad_mac[64]) begin
                        ok_next = 1'b0;
                    end
                    frac_next = pad_mac[63:0];
                    pad_next  = pad_reg - 5'd1;
                end
            end
            ST_MUL: begin
                if (step_reg != MUL_STEPS) begin
                    pp_next = {32'b0, op_a} * {32'b0, op_b};
                end
                if (step_reg != 3'd0) begin
                    prod_next = prod_reg + pp_shifted;
                end
                if (step_reg == MUL_STEPS) begin
                    state_next = ST_SUM;
                end else begin
                    step_next = step_reg + 3'd1;
                end
            end
            default: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    if (ok_reg && !(|prod_reg[127:64]) && !final_sum[64]) begin
                        out_next.amount       = final_sum[63:0];
                        out_next.amount_valid = 1'b1;
                    end else begin
                        out_next.amount       = '0;
                        out_next.amount_valid = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ok_reg    <= ok_next;
        whole_reg <= whole_next;
        frac_reg  <= frac_next;
        pad_reg   <= pad_next;
        step_reg  <= step_next;
        pp_reg    <= pp_next;
        prod_reg  <= prod_next;
        out_reg   <= out_next;
    end

endmodule

FILE: dv/dtfp_checker.sv
// checker: predicts each amount from the character beats and compares the result beats
module dtfp_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  dtfp_pkg::in_item_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  dtfp_pkg::out_item_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [63:0]         pwdata,
    input  logic                pready,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen,
    output int                  valid_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    import dtfp_pkg::*;

    localparam logic [3:0] FRAC_DIGITS_ADDR = {REG_FRACTION_DIGITS, 3'b000};
    localparam logic [3:0] UNIT_SCALE_ADDR  = {REG_UNIT_SCALE, 3'b000};
    localparam int         SHOW_LIMIT       = 10;

    // register copies
    logic [4:0]  frac_places;
    logic [63:0] unit_scale;

    // string in progress
    logic        in_frac;
    logic        have_whole;
    logic        bad_text;
    logic [63:0] whole_sum;
    logic [63:0] frac_sum;
    logic [4:0]  frac_seen;

    out_item_t   amounts_due [$];
    int          mismatches;
    int          n_results;
    int          n_valid;

    // acc * 10 + dig in wide arithmetic, top bit set on overflow
    function automatic logic [64:0] shift_in_digit(input logic [63:0] acc, input logic [3:0] dig);
        logic [127:0] wide;
        wide = 128'(acc) * 128'd10 + 128'(dig);
        return {|wide[127:64], wide[63:0]};
    endfunction

    // pad the fraction, scale the whole part, add up
    function automatic out_item_t settle_amount(input logic ok_in, input logic [63:0] whole,
                                                input logic [63:0] frac, input logic [4:0] seen,
                                                input logic [4:0] places,
                                                input logic [63:0] scale);
        out_item_t   res;
        logic        ok;
        logic [63:0] padded;
        logic [64:0] step;
        logic [127:0] prod;
        logic [64:0] sum;
        ok = ok_in;
        padded = frac;
        for (int i = int'(seen); i < int'(places); i++) begin
            if (ok) begin
                step = shift_in_digit(padded, 4'd0);
                if (step[64]) ok = 1'b0;
                else padded = step[63:0];
            end
        end
        prod = 128'(whole) * 128'(scale);
        if (prod[127:64] != 64'd0) ok = 1'b0;
        sum = {1'b0, prod[63:0]} + {1'b0, padded};
        if (sum[64]) ok = 1'b0;
        res.amount       = ok ? sum[63:0] : 64'd0;
        res.amount_valid = ok;
        return res;
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t   want;
        logic [64:0] step;
        logic [3:0]  dig;
        logic        is_dig;
        if (!aresetn) begin
            frac_places = 5'd0;
            unit_scale  = 64'd1;
            in_frac     = 1'b0;
            have_whole  = 1'b0;
            bad_text    = 1'b0;
            whole_sum   = 64'd0;
            frac_sum    = 64'd0;
            frac_seen   = 5'd0;
            amounts_due.delete();
            mismatches  = 0;
            n_results   = 0;
            n_valid     = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == FRAC_DIGITS_ADDR) frac_places = pwdata[4:0];
                else if (paddr == UNIT_SCALE_ADDR) unit_scale = pwdata;
            end

            if (m_valid && m_ready) begin
                n_results++;
                if (m_data.amount_valid === 1'b1) n_valid++;
                if (amounts_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= SHOW_LIMIT)
                        $display("%0t: result beat with nothing pending: amount %0d valid %0b",
                                 $realtime, m_data.amount, m_data.amount_valid);
                end else begin
                    want = amounts_due.pop_front();
                    if (m_data.amount !== want.amount ||
                        m_data.amount_valid !== want.amount_valid) begin
                        mismatches++;
                        if (mismatches <= SHOW_LIMIT) begin
                            $display("%0t: result %0d: expected amount %0d valid %0b",
                                     $realtime, n_results, want.amount, want.amount_valid);
                            $display("%0t: result %0d: got amount %0d valid %0b",
                                     $realtime, n_results, m_data.amount,
                                     m_data.amount_valid);
                        end
                    end
                end
            end

            if (s_valid && s_ready) begin
                is_dig = s_data.ch >= CH_ZERO && s_data.ch <= CH_NINE;
                dig    = 4'(s_data.ch - CH_ZERO);
                if (s_data.char_present) begin
                    if (!in_frac) begin
                        if (s_data.ch == CH_DOT) begin
                            in_frac = 1'b1;
                        end else if (is_dig) begin
                            have_whole = 1'b1;
                            step = shift_in_digit(whole_sum, dig);
                            if (step[64]) bad_text = 1'b1;
                            else whole_sum = step[63:0];
                        end else begin
                            bad_text = 1'b1;
                        end
                    end else if (!is_dig) begin
                        bad_text = 1'b1;
                    end else begin
                        if (frac_seen < FRAC_COUNT_MAX) frac_seen++;
                        if (frac_seen > frac_places) begin
                            bad_text = 1'b1;
                        end else begin
                            step = shift_in_digit(frac_sum, dig);
                            if (step[64]) bad_text = 1'b1;
                            else frac_sum = step[63:0];
                        end
                    end
                end
                if (s_data.is_last) begin
                    amounts_due.insert(amounts_due.size(),
                                       settle_amount(have_whole && !bad_text, whole_sum,
                                                     frac_sum, frac_seen, frac_places,
                                                     unit_scale));
                    in_frac    = 1'b0;
                    have_whole = 1'b0;
                    bad_text   = 1'b0;
                    whole_sum  = 64'd0;
                    frac_sum   = 64'd0;
                    frac_seen  = 5'd0;
                end
            end
        end
        fail_count   <= mismatches;
        pending      <= amounts_due.size();
        results_seen <= n_results;
        valid_seen   <= n_valid;
    end

endmodule

FILE: dv/tb_top.sv
// testbench top: clock, reset, register writes, character beat stimulus and verdict
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dtfp_pkg::*;

    // register byte addresses: the unit scale is 64 bits wide, so registers sit 8 apart
    localparam logic [3:0] FRAC_DIGITS_ADDR = {REG_FRACTION_DIGITS, 3'b000};
    localparam logic [3:0] UNIT_SCALE_ADDR  = {REG_UNIT_SCALE, 3'b000};

    // back end runs up to 31 padding steps besides its multiply and sum; leave room past that
    localparam int TAIL_CYCLES       = 64;
    // cycles without any beat before the run is declared hung
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int ITEMS_PER_SETTING = 155;
    localparam int N_SETTINGS        = 7;

    // register settings walked through by the random part
    // fraction places 0 and 19 are the range ends, 31 the field maximum (padding overflow)
    localparam logic [4:0]  FD_LIST [N_SETTINGS] = '{5'd0, 5'd19, 5'd6, 5'd19, 5'd31,
                                                     5'd18, 5'd3};
    localparam logic [63:0] BU_LIST [N_SETTINGS] = '{64'd1, 64'd10000000000000000000,
                                                     64'd1000000, 64'hFFFF_FFFF_FFFF_FFFF,
                                                     64'd0, 64'd1000000000000000000,
                                                     64'd1000};
    // the setting whose base unit is drawn at random instead of taken from the list
    localparam int RANDOM_BASE_SETTING = 6;
    // the setting run with no idling on either side
    localparam int CALM_SETTING        = 2;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    in_item_t    s_data  = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [3:0]  paddr   = 4'd0;
    logic [63:0] pwdata  = 64'd0;
    logic [63:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending;
    int          results_seen;
    int          valid_seen;

    // no random idling while set
    logic        calm    = 1'b0;
    // random ignored beats (no character, not last) inside strings
    bit          gaps_on = 1'b0;

    in_item_t    text [$];
    int          items_sent;
    int          settings_done;
    int          quiet_cycles;

    initial forever #10 aclk = ~aclk;

    decimal_text_to_fixed_point_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    dtfp_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .valid_seen   (valid_seen)
    );

    // result side: back-pressure with a chance of about 7 in 100 outside the calm stretch
    always @(posedge aclk) begin
        m_ready <= calm || ($urandom_range(0, 99) >= 7);
    end

    // watchdog: any accepted beat on either channel restarts the count
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles, %0d results still due",
                     WATCHDOG_LIMIT, pending);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // apb write: setup cycle, then access cycle; register takes it at the end of the access cycle
    task automatic reg_write(input logic [3:0] addr, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // keeps back-to-back writes from touching psel twice in one step
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic [4:0] places, input logic [63:0] scale);
        reg_write(FRAC_DIGITS_ADDR, {59'd0, places});
        reg_write(UNIT_SCALE_ADDR, scale);
        settings_done++;
    endtask

    // one character beat; valid stays up from beat to beat unless an idle cycle is drawn
    task automatic send_beat(input in_item_t beat);
        while (!calm && $urandom_range(0, 99) < 7) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        items_sent++;
    endtask

    // ignored beat: no character, not the end of the string
    task automatic add_gap();
        text.insert(text.size(),
                    '{ch: 8'($urandom_range(0, 255)), char_present: 1'b0, is_last: 1'b0});
    endtask

    task automatic add_char(input logic [7:0] c);
        if (gaps_on && $urandom_range(0, 99) < 4) add_gap();
        text.insert(text.size(), '{ch: c, char_present: 1'b1, is_last: 1'b0});
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) add_char(s[i]);
    endtask

    task automatic add_digits(input int n, input bit zeros_only);
        repeat (n) add_char(zeros_only ? CH_ZERO : CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // close the string either on its last character or with a separate end marker
    // (an empty string always gets the marker), then send it
    task automatic finish_text(input bit end_marker);
        if (end_marker || text.size() == 0)
            text.insert(text.size(), '{ch: 8'($urandom_range(0, 255)), char_present: 1'b0,
                                       is_last: 1'b1});
        else
            text[text.size() - 1].is_last = 1'b1;
        foreach (text[i]) send_beat(text[i]);
        text.delete();
    endtask

    // one random string: mostly well-formed amounts, some near the 64-bit limit,
    // some broken ones, empty strings and plain noise
    task automatic random_text(input logic [4:0] places);
        int          kind;
        int          pick;
        int          nw;
        int          nf;
        int          pos;
        logic [7:0]  junk;
        kind = $urandom_range(0, 99);
        if (kind < 88) begin
            if (kind >= 62 && kind < 74) begin
                // whole part of 19 or 20 digits, around, at or past 2^64-1
                case ($urandom_range(0, 2))
                    0:       add_text("18446744073709551615");
                    1:       add_text("18446744073709551616");
                    default: add_digits($urandom_range(19, 20), 1'b0);
                endcase
            end else begin
                // short whole parts dominate, a few long ones
                pick = $urandom_range(0, 99);
                nw = (pick < 70) ? $urandom_range(1, 4) :
                     (pick < 95) ? $urandom_range(5, 12) : $urandom_range(13, 20);
                add_digits(nw, 1'b0);
            end
            if ($urandom_range(0, 2) != 0) begin
                add_char(CH_DOT);
                // occasionally one fraction digit too many
                if (places < FRAC_COUNT_MAX && $urandom_range(0, 9) == 0)
                    nf = int'(places) + 1;
                else
                    nf = $urandom_range(0, int'(places));
                add_digits(nf, $urandom_range(0, 7) == 0);
            end
            if (kind >= 74) begin
                // break the string
                pos  = $urandom_range(0, text.size() - 1);
                junk = 8'($urandom_range(0, 255));
                case ($urandom_range(0, 4))
                    0: text.push_front('{ch: CH_MINUS, char_present: 1'b1, is_last: 1'b0});
                    1: text.push_front('{ch: CH_DOT, char_present: 1'b1, is_last: 1'b0});
                    2: text[pos] = '{ch: CH_MINUS, char_present: 1'b1, is_last: 1'b0};
                    3: text[pos] = '{ch: CH_DOT, char_present: 1'b1, is_last: 1'b0};
                    default: text[pos] = '{ch: junk, char_present: 1'b1, is_last: 1'b0};
                endcase
            end
        end else if (kind >= 93) begin
            // raw bytes over the full 8-bit range
            repeat ($urandom_range(1, 6)) add_char(8'($urandom_range(0, 255)));
        end
        // kinds 88 to 92 leave the text empty: an empty string
        finish_text($urandom_range(0, 4) == 0);
    endtask

    // stop sending, wait for every pending result, then let the back end settle
    // before anything touches the registers
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    initial begin : stimulus
        int          phase_start;
        logic [63:0] scale;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed strings at two fraction places, base unit 100
        apply_setting(5'd2, 64'd100);
        finish_text(1'b1);                  // empty string
        add_text("-5");    finish_text(1'b0);   // leading minus
        add_text(".5");    finish_text(1'b0);   // no whole part
        add_text("9.");    finish_text(1'b0);   // dot with nothing after it
        add_text("1.5");   finish_text(1'b0);   // padded fraction
        add_text("1.234"); finish_text(1'b0);   // too many fraction digits
        add_text("2..");   finish_text(1'b0);   // second dot
        add_text("4");     add_gap(); finish_text(1'b1);   // ignored beat, then end marker
        add_char(8'hFF);   finish_text(1'b0);   // top-bit byte in the whole part
        add_text("0");     finish_text(1'b0);   // smallest amount
        drain();

        // random strings under each register setting; each phase ends drained
        gaps_on = 1'b1;
        for (int p = 0; p < N_SETTINGS; p++) begin
            calm  <= (p == CALM_SETTING);
            scale = (p == RANDOM_BASE_SETTING) ? {$urandom(), $urandom()} : BU_LIST[p];
            apply_setting(FD_LIST[p], scale);
            phase_start = items_sent;
            while (items_sent - phase_start < ITEMS_PER_SETTING) random_text(FD_LIST[p]);
            drain();
        end

        $display("run covered %0d character beats under %0d register settings",
                 items_sent, settings_done);
        $display("%0d results compared, %0d of them valid amounts", results_seen, valid_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
